// ----- hw/rtl/sacl_pkg.sv -----
package sacl_pkg;

  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_WIDTH = 32;

  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int WAY_W     = 3;
  localparam int WAY_CNT_W = 4;
  localparam int AGE_W     = 3;
  localparam int TAG_W     = ADDR_WIDTH;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int SHIFT_W   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_reg_t;

  // One set: all ways side by side in a single memory word.
  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
  } row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } way_res_t;

  // Contents of a set that was never written since reset.
  function automatic row_t reset_row();
    row_t r;
    r.valid = '0;
    r.tag   = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      r.age[j] = AGE_W'(j);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sacl_set_ram.sv -----
module sacl_set_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [sacl_pkg::SET_W-1:0]   wr_addr,
  input  sacl_pkg::row_t               wr_data,
  input  logic                         rd_en,
  input  logic [sacl_pkg::SET_W-1:0]   rd_addr,
  output sacl_pkg::row_t               rd_data
);

  sacl_pkg::row_t mem [sacl_pkg::MAX_SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/sacl_way_logic.sv -----
module sacl_way_logic (
  input  sacl_pkg::row_t                   row_in,
  input  logic [sacl_pkg::TAG_W-1:0]       tag,
  input  logic [sacl_pkg::WAY_CNT_W-1:0]   ways,
  output sacl_pkg::row_t                   row_out,
  output sacl_pkg::way_res_t               res
);

  logic [sacl_pkg::MAX_WAYS-1:0] in_use;
  logic [sacl_pkg::MAX_WAYS-1:0] match;
  logic                          found;
  logic [sacl_pkg::WAY_W-1:0]    hit_way;
  logic [sacl_pkg::WAY_W-1:0]    victim;
  logic [sacl_pkg::WAY_W-1:0]    sel;
  logic [sacl_pkg::AGE_W-1:0]    ref_age;
  logic [sacl_pkg::AGE_W-1:0]    top;

  always_comb begin
    for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
      in_use[w] = (sacl_pkg::WAY_CNT_W'(w) < ways);
      match[w]  = in_use[w] && row_in.valid[w] && (row_in.tag[w] == tag);
    end

    // lowest-numbered matching way wins
    found   = 1'b0;
    hit_way = '0;
    for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
      if (match[w] && !found) begin
        found   = 1'b1;
        hit_way = sacl_pkg::WAY_W'(w);
      end
    end

    // LRU victim: lowest-numbered way with the smallest age
    victim = '0;
    for (int w = 1; w < sacl_pkg::MAX_WAYS; w++) begin
      if (in_use[w] && (row_in.age[w] < row_in.age[victim])) begin
        victim = sacl_pkg::WAY_W'(w);
      end
    end

    sel     = found ? hit_way : victim;
    ref_age = row_in.age[sel];
    top     = sacl_pkg::AGE_W'(ways - sacl_pkg::WAY_CNT_W'(1));

    row_out = row_in;
    for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
      if (in_use[w] && (sacl_pkg::WAY_W'(w) != sel)) begin
        if (found ? (row_in.age[w] > ref_age) : (row_in.age[w] != '0)) begin
          row_out.age[w] = row_in.age[w] - sacl_pkg::AGE_W'(1);
        end
      end
    end
    row_out.age[sel] = top;
    if (!found) begin
      row_out.valid[sel] = 1'b1;
      row_out.tag[sel]   = tag;
    end

    res.hit = found;
    res.way = sel;
  end

endmodule

// ----- hw/rtl/set_assoc_cache_lru_lookup.sv -----
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_ready   address[31:0]
// out       out  out_valid / out_ready hit, way_used[2:0]
// cfg       in   cfg_write             cfg_index[1:0], cfg_data[3:0]
//
// Each item takes two steps: the set row is read from the set RAM, then
// compared/updated and written back through the RAM's write port.
// Reset clears the per-set init bits at once; no clearing pass is needed.
// A result waiting in the output register stalls the lookup stage, and the
// lookup stage must finish before the next item is taken.
module set_assoc_cache_lru_lookup (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sacl_pkg::ADDR_WIDTH-1:0] address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [sacl_pkg::WAY_W-1:0]      way_used
);

  // config registers
  logic [sacl_pkg::CFG_W-1:0] offset_bits;
  logic [sacl_pkg::CFG_W-1:0] index_bits;
  logic [sacl_pkg::CFG_W-1:0] ways_in_use;

  // clamped views
  logic [sacl_pkg::CFG_W-1:0]     ib_eff;
  logic [sacl_pkg::WAY_CNT_W-1:0] ways_eff;

  // address decode for the item on the input port
  logic [sacl_pkg::ADDR_WIDTH-1:0] addr_sh;
  logic [sacl_pkg::SET_W-1:0]      set_mask;
  logic [sacl_pkg::SET_W-1:0]      set_now;
  logic [sacl_pkg::TAG_W-1:0]      tag_now;

  // lookup stage
  logic                            busy;
  logic [sacl_pkg::SET_W-1:0]      s_set;
  logic [sacl_pkg::TAG_W-1:0]      s_tag;
  logic [sacl_pkg::WAY_CNT_W-1:0]  s_ways;
  logic                            s_row_init;

  logic [sacl_pkg::MAX_SETS-1:0]   set_init;

  logic                            accept;
  logic                            advance;
  sacl_pkg::row_t                  rd_row;
  sacl_pkg::row_t                  cur_row;
  sacl_pkg::row_t                  new_row;
  sacl_pkg::way_res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= sacl_pkg::CFG_W'(4);
      index_bits  <= sacl_pkg::CFG_W'(6);
      ways_in_use <= sacl_pkg::CFG_W'(4);
    end else if (cfg_write) begin
      unique case (sacl_pkg::cfg_reg_t'(cfg_index))
        sacl_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data;
        sacl_pkg::CFG_INDEX_BITS:  index_bits  <= cfg_data;
        sacl_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // out-of-range settings: ways 0 acts as 1, above MAX_WAYS as MAX_WAYS;
  // index bits never exceed the set RAM depth
  always_comb begin
    if (ways_in_use == '0) begin
      ways_eff = sacl_pkg::WAY_CNT_W'(1);
    end else if (ways_in_use > sacl_pkg::WAY_CNT_W'(sacl_pkg::MAX_WAYS)) begin
      ways_eff = sacl_pkg::WAY_CNT_W'(sacl_pkg::MAX_WAYS);
    end else begin
      ways_eff = ways_in_use;
    end
    ib_eff = (index_bits > sacl_pkg::CFG_W'(sacl_pkg::SET_W)) ?
             sacl_pkg::CFG_W'(sacl_pkg::SET_W) : index_bits;
  end

  assign addr_sh  = address >> offset_bits;
  assign set_mask = sacl_pkg::SET_W'(((sacl_pkg::SET_W+1)'(1) << ib_eff)
                                     - (sacl_pkg::SET_W+1)'(1));
  assign set_now  = sacl_pkg::SET_W'(addr_sh) & set_mask;
  assign tag_now  = address >> (sacl_pkg::SHIFT_W'(offset_bits)
                                + sacl_pkg::SHIFT_W'(ib_eff));

  // one item at a time: the write-back lands before the next read, so
  // same-set items never overlap
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign advance  = busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      set_init  <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (advance) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        set_init[s_set] <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_set      <= set_now;
      s_tag      <= tag_now;
      s_ways     <= ways_eff;
      s_row_init <= set_init[set_now];
    end
    if (advance) begin
      hit      <= res.hit;
      way_used <= res.way;
    end
  end

  sacl_set_ram u_ram (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (s_set),
    .wr_data (new_row),
    .rd_en   (accept),
    .rd_addr (set_now),
    .rd_data (rd_row)
  );

  // a set untouched since reset reads as all-invalid with ages 0..ways-1
  assign cur_row = s_row_init ? rd_row : sacl_pkg::reset_row();

  sacl_way_logic u_way (
    .row_in  (cur_row),
    .tag     (s_tag),
    .ways    (s_ways),
    .row_out (new_row),
    .res     (res)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !in_ready)
    else $error("lookup stage not busy after accept");

  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy && !out_valid |=> !busy && out_valid)
    else $error("lookup did not complete into empty output register");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    advance |-> busy && !accept)
    else $error("write-back overlaps a new read");

  a_init_mark: assert property (@(posedge clk) disable iff (rst)
    advance |=> set_init[$past(s_set)])
    else $error("set not marked written after write-back");

endmodule

// ----- sim/set_assoc_cache_lru_lookup_tb.sv -----
module set_assoc_cache_lru_lookup_tb;

  // Scoreboard: keeps its own copy of the tag/valid/age arrays and the live
  // geometry registers. Every accepted address is run through the LRU update
  // here, and the outcome (hit, way) queues up for the result checker.
  class lru_lookup_board;
    bit [sacl_pkg::CFG_W-1:0] offset_reg;
    bit [sacl_pkg::CFG_W-1:0] index_reg;
    bit [sacl_pkg::CFG_W-1:0] ways_reg;
    bit                       line_valid [sacl_pkg::MAX_SETS][sacl_pkg::MAX_WAYS];
    bit [sacl_pkg::TAG_W-1:0] line_tag [sacl_pkg::MAX_SETS][sacl_pkg::MAX_WAYS];
    bit [sacl_pkg::AGE_W-1:0] line_age [sacl_pkg::MAX_SETS][sacl_pkg::MAX_WAYS];
    sacl_pkg::way_res_t       pending_lookups [$];
    int                       errors;

    function new();
      offset_reg = 4;
      index_reg  = 6;
      ways_reg   = 4;
      errors     = 0;
      foreach (line_age[s, w]) begin
        line_valid[s][w] = 1'b0;
        line_tag[s][w]   = '0;
        line_age[s][w]   = sacl_pkg::AGE_W'(w);
      end
    endfunction

    function void write_reg(sacl_pkg::cfg_reg_t idx, bit [sacl_pkg::CFG_W-1:0] v);
      unique case (idx)
        sacl_pkg::CFG_OFFSET_BITS: offset_reg = v;
        sacl_pkg::CFG_INDEX_BITS:  index_reg  = v;
        sacl_pkg::CFG_WAYS_IN_USE: ways_reg   = v;
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_address(bit [sacl_pkg::ADDR_WIDTH-1:0] a);
      int                       ways;
      int                       ib;
      int                       off;
      int                       s;
      int                       sel;
      int                       w;
      bit                       found;
      bit [63:0]                tg;
      bit [sacl_pkg::AGE_W-1:0] top;
      bit [sacl_pkg::AGE_W-1:0] hit_age;
      sacl_pkg::way_res_t       r;
      ways = ways_reg;
      if (ways < 1) ways = 1;
      if (ways > sacl_pkg::MAX_WAYS) ways = sacl_pkg::MAX_WAYS;
      // index bits clamp so the set count never exceeds the array
      ib = index_reg;
      while (ib > 0 && (1 << ib) > sacl_pkg::MAX_SETS) ib--;
      off   = offset_reg;
      s     = int'((a >> off) & ((32'd1 << ib) - 32'd1));
      tg    = {32'd0, a} >> (off + ib);
      top   = sacl_pkg::AGE_W'(ways - 1);
      found = 1'b0;
      sel   = 0;
      // lowest-numbered matching way wins
      for (w = 0; w < ways; w++) begin
        if (!found && line_valid[s][w] && line_tag[s][w] == tg[sacl_pkg::TAG_W-1:0]) begin
          sel   = w;
          found = 1'b1;
        end
      end
      if (found) begin
        hit_age = line_age[s][sel];
        for (w = 0; w < ways; w++) begin
          if (w != sel && line_age[s][w] > hit_age) line_age[s][w]--;
        end
      end else begin
        // victim: smallest age, lowest way on a tie; others saturate at 0
        for (w = 1; w < ways; w++) begin
          if (line_age[s][w] < line_age[s][sel]) sel = w;
        end
        for (w = 0; w < ways; w++) begin
          if (w != sel && line_age[s][w] > 0) line_age[s][w]--;
        end
        line_valid[s][sel] = 1'b1;
        line_tag[s][sel]   = tg[sacl_pkg::TAG_W-1:0];
      end
      line_age[s][sel] = top;
      r.hit = found;
      r.way = sacl_pkg::WAY_W'(sel);
      pending_lookups = {pending_lookups, r};
    endfunction

    function void check_result(logic h, logic [sacl_pkg::WAY_W-1:0] w);
      sacl_pkg::way_res_t e;
      if (pending_lookups.size() == 0) begin
        flag($sformatf("result with no item pending: hit=%0b way=%0d", h, w));
        return;
      end
      e = pending_lookups.pop_front();
      if (h !== e.hit)
        flag($sformatf("hit mismatch: expected %0b, got %0b", e.hit, h));
      if (w !== e.way)
        flag($sformatf("way_used mismatch: expected %0d, got %0d", e.way, w));
    endfunction

    function int outstanding();
      return pending_lookups.size();
    endfunction

    function void close_out();
      if (pending_lookups.size() != 0)
        flag($sformatf("%0d results never arrived", pending_lookups.size()));
    endfunction
  endclass

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index = sacl_pkg::CFG_OFFSET_BITS;
  logic [sacl_pkg::CFG_W-1:0]      cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  logic [sacl_pkg::ADDR_WIDTH-1:0] address   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            hit;
  logic [sacl_pkg::WAY_W-1:0]      way_used;

  lru_lookup_board board;
  // set per phase: when high, neither side idles (back-to-back traffic)
  bit no_idle = 1'b0;

  set_assoc_cache_lru_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .address   (address),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .way_used  (way_used)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("set_assoc_cache_lru_lookup regression: fail");
    $finish;
  end

  function automatic int draw_pause();
    return no_idle ? 0 : int'($urandom_range(0, 18));
  endfunction

  // Drive one address: optional idle cycles first, then hold valid until
  // the block takes it. Valid stays up across back-to-back items.
  task automatic send_address(input logic [sacl_pkg::ADDR_WIDTH-1:0] a, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    address  = a;
    do @(posedge clk); while (!in_ready);
    board.note_address(a);
  endtask

  // Drop valid and wait until every queued lookup has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Geometry changes only while the block is empty.
  task automatic set_geometry(input bit [sacl_pkg::CFG_W-1:0] off,
                              input bit [sacl_pkg::CFG_W-1:0] ib,
                              input bit [sacl_pkg::CFG_W-1:0] ways);
    drain();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = sacl_pkg::CFG_OFFSET_BITS;
    cfg_data  = off;
    board.write_reg(sacl_pkg::CFG_OFFSET_BITS, off);
    @(negedge clk);
    cfg_index = sacl_pkg::CFG_INDEX_BITS;
    cfg_data  = ib;
    board.write_reg(sacl_pkg::CFG_INDEX_BITS, ib);
    @(negedge clk);
    cfg_index = sacl_pkg::CFG_WAYS_IN_USE;
    cfg_data  = ways;
    board.write_reg(sacl_pkg::CFG_WAYS_IN_USE, ways);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Result side: random back-pressure per item, check at the accepting edge.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_pause();
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(hit, way_used);
    end
  end

  initial begin
    int                              off_v;
    int                              ib_v;
    int                              ways_v;
    int                              eff_ib;
    int                              eff_ways;
    int                              nsets;
    int                              ntags;
    int                              plen;
    int                              sent;
    int                              i;
    logic [31:0]                     tag_pool [12];
    int                              set_pool [4];
    bit [63:0]                       v;
    logic [sacl_pkg::ADDR_WIDTH-1:0] a;

    board = new();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Reset geometry: 16-byte lines, 64 sets, 4 ways.
    send_address(32'h0000_0000, 0);     // cold miss, way 0
    send_address(32'h0000_0000, 0);     // hit on the line just filled
    send_address(32'hFFFF_FFFF, 2);     // top set, all-ones tag
    send_address(32'h0000_0400, 0);     // fill set 0 ways 1..3
    send_address(32'h0000_0800, 1);
    send_address(32'h0000_0C00, 0);
    send_address(32'h0000_1000, 0);     // set full: LRU victim
    send_address(32'h0000_0404, 0);     // hit on the least recently used line
    send_address(32'h0000_0000, 3);     // evicted tag misses again

    // Out-of-range registers: offset past 12, index past 8, ways past 8.
    set_geometry(4'd15, 4'd15, 4'd15);
    send_address(32'h8000_0000, 0);
    send_address(32'hFFFF_FFFF, 0);
    send_address(32'hFFFF_FFFF, 0);

    // Zero ways behaves as direct-mapped, one set, byte lines.
    set_geometry(4'd0, 4'd0, 4'd0);
    send_address(32'h0000_0000, 0);
    send_address(32'h0000_0001, 0);
    send_address(32'h0000_0001, 0);

    // Fill all 8 ways, narrow to 2 ways so a tag already held in a high
    // way gets a second copy low, then widen again: two ways match.
    set_geometry(4'd0, 4'd0, 4'd8);
    for (i = 0; i < 8; i++) send_address(32'h10 + i, 0);
    set_geometry(4'd0, 4'd0, 4'd2);
    send_address(32'h15, 0);
    set_geometry(4'd0, 4'd0, 4'd8);
    send_address(32'h15, 0);

    // Random phases: fresh geometry each phase (extremes included), traffic
    // mostly to a small working set of sets/tags so hits and evictions mix,
    // with some fully random addresses as noise.
    sent = 0;
    while (sent < 1400) begin
      case ($urandom_range(0, 5))
        0: off_v = 0;
        1: off_v = 12;
        2: off_v = $urandom_range(13, 15);
        default: off_v = $urandom_range(0, 12);
      endcase
      case ($urandom_range(0, 5))
        0: ib_v = 0;
        1: ib_v = 8;
        2: ib_v = $urandom_range(9, 15);
        default: ib_v = $urandom_range(0, 8);
      endcase
      case ($urandom_range(0, 5))
        0: ways_v = 0;
        1: ways_v = 8;
        2: ways_v = $urandom_range(9, 15);
        default: ways_v = $urandom_range(1, 8);
      endcase
      set_geometry(sacl_pkg::CFG_W'(off_v), sacl_pkg::CFG_W'(ib_v),
                   sacl_pkg::CFG_W'(ways_v));
      eff_ib   = (ib_v > 8) ? 8 : ib_v;
      eff_ways = (ways_v < 1) ? 1 : ((ways_v > 8) ? 8 : ways_v);
      no_idle  = ($urandom_range(0, 3) == 0);
      nsets = $urandom_range(1, 4);
      ntags = $urandom_range(1, eff_ways + 3);
      for (i = 0; i < nsets; i++)
        set_pool[i] = int'($urandom & ((32'd1 << eff_ib) - 32'd1));
      for (i = 0; i < ntags; i++) tag_pool[i] = $urandom;
      plen = $urandom_range(40, 160);
      repeat (plen) begin
        if ($urandom_range(0, 4) == 0) begin
          a = $urandom;
        end else begin
          v = ({32'd0, tag_pool[$urandom_range(0, ntags - 1)]} << (off_v + eff_ib))
            | (64'(set_pool[$urandom_range(0, nsets - 1)]) << off_v)
            | 64'($urandom & ((32'd1 << off_v) - 32'd1));
          a = v[sacl_pkg::ADDR_WIDTH-1:0];
        end
        send_address(a, draw_pause());
        sent++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    board.close_out();
    if (board.errors == 0) begin
      $display("set_assoc_cache_lru_lookup regression: pass");
    end else begin
      $display("set_assoc_cache_lru_lookup regression: fail");
    end
    $finish;
  end

endmodule
